[hw/rtl/pidq_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pidq_pkg: shared types and constants of the process identifier deque
// Operation codes, status codes and the control word broadcast to every cell.
// ----------------------------------------------------------------------------
package pidq_pkg;

    localparam int DEPTH_DEF   = 16;
    localparam int ID_BITS_DEF = 22;
    localparam int FUNC_W      = 2;
    localparam int STATUS_W    = 2;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_ADD_FRONT  = 2'd0,
        FUNC_ADD_BACK   = 2'd1,
        FUNC_TAKE_FRONT = 2'd2,
        FUNC_DELETE     = 2'd3
    } t_func;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_EMPTY     = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_FULL      = 2'd3
    } t_status;

    // Broadcast to all cells: whether to act this cycle and on what
    typedef struct packed {
        logic  en;
        t_func func;
    } t_cell_ctrl;

endpackage
`default_nettype wire

[hw/rtl/pidq_cell.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pidq_cell: one storage cell of the deque
// Holds one identifier; shifts towards the back or the front, loads at the
// tail, and takes part in the first-match chain of a delete.
// ----------------------------------------------------------------------------
module pidq_cell #(
    parameter int ID_BITS = pidq_pkg::ID_BITS_DEF
) (
    input  wire                       i_clk,
    input  wire pidq_pkg::t_cell_ctrl i_ctrl,
    input  wire [ID_BITS-1:0]         i_id,         // identifier of the beat
    input  wire                       i_occ,        // this cell holds an entry
    input  wire                       i_is_tail,    // first free cell
    input  wire [ID_BITS-1:0]         i_left_data,  // neighbour nearer the front
    input  wire [ID_BITS-1:0]         i_right_data, // neighbour nearer the back
    input  wire                       i_hit,        // match somewhere in front
    output logic [ID_BITS-1:0]        o_data,
    output logic                      o_hit
);

    logic [ID_BITS-1:0] r_data;
    logic               w_match;

    assign w_match = i_occ && (r_data == i_id) && (i_ctrl.func == pidq_pkg::FUNC_DELETE);
    assign o_hit   = i_hit | w_match;
    assign o_data  = r_data;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.en) begin
            case (i_ctrl.func)
                pidq_pkg::FUNC_ADD_FRONT: r_data <= i_left_data;
                pidq_pkg::FUNC_ADD_BACK: begin
                    if (i_is_tail) begin
                        r_data <= i_id;
                    end
                end
                pidq_pkg::FUNC_TAKE_FRONT: r_data <= i_right_data;
                pidq_pkg::FUNC_DELETE: begin
                    // close the gap from the matching cell onwards
                    if (o_hit) begin
                        r_data <= i_right_data;
                    end
                end
                default: r_data <= r_data;
            endcase
        end
    end

endmodule
`default_nettype wire

[hw/rtl/process_id_deque_core.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// process_id_deque_core: bounded deque of process identifiers
// A row of shifting cells with a fill counter and a registered result beat.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel (s_axis): tuser carries the operation (push front, push
//   back, pop front, delete first match), tdata carries the identifier.
//   Response channel (m_axis): one beat per request, carrying the popped
//   identifier (zero unless a pop succeeded), the occupancy after the
//   operation and a status (ok, empty, not found, full).
// Timing:
//   Every operation, including the match search and gap close of a delete,
//   finishes in the cycle it is accepted; the response appears in the next
//   cycle from the output register. One request per cycle is sustained
//   while the receiver takes each response; the depth of the first-match
//   chain through the cells sets the cycle time.
// Reset:
//   i_rst_n (synchronous, active low) empties the deque and drops any
//   pending response. Cell contents are not cleared; only occupied cells
//   are ever read.
// Back-pressure:
//   While a response waits for m_axis_tready, a new request is taken only
//   in the cycle the waiting response leaves, so nothing is lost.
// ----------------------------------------------------------------------------
module process_id_deque_core #(
    parameter int DEPTH   = pidq_pkg::DEPTH_DEF,
    parameter int ID_BITS = pidq_pkg::ID_BITS_DEF,
    localparam int CNT_BITS = $clog2(DEPTH + 1),
    localparam int IN_W     = ((ID_BITS + 7) / 8) * 8,
    localparam int OUT_W    = ((ID_BITS + CNT_BITS + 7) / 8) * 8
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    // request channel
    input  wire                          s_axis_tvalid,
    output logic                         s_axis_tready,
    input  wire [IN_W-1:0]               s_axis_tdata,  // proc_id, zero pad
    input  wire [pidq_pkg::FUNC_W-1:0]   s_axis_tuser,  // func
    // response channel
    output logic                         m_axis_tvalid,
    input  wire                          m_axis_tready,
    output logic [OUT_W-1:0]             m_axis_tdata,  // popped_id, occupancy, zero pad
    output logic [pidq_pkg::STATUS_W-1:0] m_axis_tuser  // status
);

    // ------------------------------------------------------------------
    // Request decode
    // ------------------------------------------------------------------
    logic                 w_accept;
    pidq_pkg::t_func      w_func;
    logic [ID_BITS-1:0]   w_id;
    logic                 w_full;
    logic                 w_empty;

    logic [CNT_BITS-1:0]  r_count;
    logic [CNT_BITS-1:0]  n_count;

    logic                 r_out_valid;
    logic [ID_BITS-1:0]   r_out_popped;
    logic [ID_BITS-1:0]   n_out_popped;
    pidq_pkg::t_status    r_out_status;
    pidq_pkg::t_status    n_out_status;
    logic [CNT_BITS-1:0]  r_out_count;

    pidq_pkg::t_cell_ctrl w_ctrl;
    logic [ID_BITS-1:0]   w_data [DEPTH];
    logic                 w_hit  [DEPTH+1];
    logic                 w_found;

    // Take a new beat when the output register is free or leaving
    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_func        = pidq_pkg::t_func'(s_axis_tuser);
    assign w_id          = s_axis_tdata[ID_BITS-1:0];
    assign w_full        = (r_count == CNT_BITS'(DEPTH));
    assign w_empty       = (r_count == '0);
    assign w_found       = w_hit[DEPTH];

    // Work out status, next occupancy and the popped value
    always_comb begin
        n_count      = r_count;
        n_out_status = pidq_pkg::ST_OK;
        n_out_popped = '0;
        unique case (w_func) inside
            pidq_pkg::FUNC_ADD_FRONT, pidq_pkg::FUNC_ADD_BACK: begin
                if (w_full) begin
                    n_out_status = pidq_pkg::ST_FULL;
                end else begin
                    n_count = r_count + 1'b1;
                end
            end
            pidq_pkg::FUNC_TAKE_FRONT: begin
                if (w_empty) begin
                    n_out_status = pidq_pkg::ST_EMPTY;
                end else begin
                    n_count      = r_count - 1'b1;
                    n_out_popped = w_data[0];
                end
            end
            pidq_pkg::FUNC_DELETE: begin
                if (w_found) begin
                    n_count = r_count - 1'b1;
                end else begin
                    n_out_status = pidq_pkg::ST_NOT_FOUND;
                end
            end
            default: n_count = r_count;
        endcase
    end

    // Hold every cell on a failed push or pop; a failed delete hits no cell
    always_comb begin
        w_ctrl.func = w_func;
        w_ctrl.en   = w_accept && (n_out_status == pidq_pkg::ST_OK ||
                                   n_out_status == pidq_pkg::ST_NOT_FOUND);
    end

    // ------------------------------------------------------------------
    // Cell row: front is cell 0, back is cell r_count-1
    // ------------------------------------------------------------------
    assign w_hit[0] = 1'b0;

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic [ID_BITS-1:0] w_left;
        logic [ID_BITS-1:0] w_right;
        logic               w_occ;
        logic               w_tail;

        if (g == 0) begin : g_first
            assign w_left = w_id;          // push front enters here
        end else begin : g_inner_l
            assign w_left = w_data[g-1];
        end

        if (g == DEPTH - 1) begin : g_last
            assign w_right = '0;           // vacated back cell, never read
        end else begin : g_inner_r
            assign w_right = w_data[g+1];
        end

        assign w_occ  = (CNT_BITS'(g) < r_count);
        assign w_tail = (CNT_BITS'(g) == r_count);

        pidq_cell #(
            .ID_BITS(ID_BITS)
        ) u_cell (
            .i_clk        (i_clk),
            .i_ctrl       (w_ctrl),
            .i_id         (w_id),
            .i_occ        (w_occ),
            .i_is_tail    (w_tail),
            .i_left_data  (w_left),
            .i_right_data (w_right),
            .i_hit        (w_hit[g]),
            .o_data       (w_data[g]),
            .o_hit        (w_hit[g+1])
        );
    end

    // ------------------------------------------------------------------
    // Fill counter and response register
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;   // drop the beat once taken
            end
        end
    end

    // Payload: load on accept, hold otherwise
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out_popped <= n_out_popped;
            r_out_status <= n_out_status;
            r_out_count  <= n_count;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = OUT_W'({r_out_count, r_out_popped});
    assign m_axis_tuser  = r_out_status;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_BITS'(DEPTH))
        else $error("occupancy beyond depth");

    a_full_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && w_full &&
        (w_func == pidq_pkg::FUNC_ADD_FRONT || w_func == pidq_pkg::FUNC_ADD_BACK)
        |=> r_out_status == pidq_pkg::ST_FULL && r_count == $past(r_count))
        else $error("push on full deque changed occupancy");

    a_pop_dec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && !w_empty && w_func == pidq_pkg::FUNC_TAKE_FRONT
        |=> r_count == $past(r_count) - 1'b1)
        else $error("pop did not shrink the deque");

    a_out_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> r_out_count == r_count)
        else $error("reported occupancy differs from fill count");

endmodule
`default_nettype wire
